FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the decrypt core.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/core/aesd_pkg.sv
// Shared types, S-box tables and GF(2^8) helpers for the AES-128 decrypt core.
// Depends on nothing.
package aesd_pkg;

   localparam int NumRounds = 10;

   typedef logic [127:0] block_type;

   // Beat traveling down the round chain.
   typedef struct packed {
      logic      valid;
      block_type data;
   } stage_type;

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
      logic [7:0] p;
      logic [7:0] x;
      p = 8'h00;
      x = a;
      for (int i = 0; i < 4; i++) begin
         if (b[i]) p = p ^ x;
         x = xtime(x);
      end
      gmul = p;
   endfunction

   function automatic logic [7:0] gf_inv(input logic [7:0] a);
      logic [7:0] acc;
      logic [7:0] base;
      logic [7:0] e;
      logic [7:0] p;
      logic [7:0] x;
      acc = 8'h01;
      base = a;
      e = 8'd254;
      for (int k = 0; k < 8; k++) begin
         if (e[0]) begin
            p = 8'h00;
            x = acc;
            for (int i = 0; i < 8; i++) begin
               if (base[i]) p = p ^ x;
               x = xtime(x);
            end
            acc = p;
         end
         p = 8'h00;
         x = base;
         for (int i = 0; i < 8; i++) begin
            if (base[i]) p = p ^ x;
            x = xtime(x);
         end
         base = p;
         e = e >> 1;
      end
      gf_inv = (a == 8'h00) ? 8'h00 : acc;
   endfunction

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] v;
      v = gf_inv(a);
      sbox = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]}
           ^ {v[3:0], v[7:4]} ^ 8'h63;
   endfunction

   // Constant inverse S-box, folded at elaboration.
   function automatic logic [255:0][7:0] build_inv_sbox();
      logic [255:0][7:0] t;
      for (int x = 0; x < 256; x++) t[sbox(8'(x))] = 8'(x);
      return t;
   endfunction

   // Constant forward S-box, folded at elaboration.
   function automatic logic [255:0][7:0] build_fwd_sbox();
      logic [255:0][7:0] t;
      for (int x = 0; x < 256; x++) t[x] = sbox(8'(x));
      return t;
   endfunction

   localparam logic [255:0][7:0] InvSbox = build_inv_sbox();
   localparam logic [255:0][7:0] FwdSbox = build_fwd_sbox();

   function automatic logic [7:0] fwd_sub(input logic [7:0] a);
      fwd_sub = FwdSbox[a];
   endfunction

   function automatic block_type inv_mix(input block_type s);
      block_type o;
      logic [7:0] a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         a0 = s[32*c +: 8];
         a1 = s[32*c+8 +: 8];
         a2 = s[32*c+16 +: 8];
         a3 = s[32*c+24 +: 8];
         o[32*c +: 8]    = gmul(a0, 4'd14) ^ gmul(a1, 4'd11) ^ gmul(a2, 4'd13) ^ gmul(a3, 4'd9);
         o[32*c+8 +: 8]  = gmul(a0, 4'd9) ^ gmul(a1, 4'd14) ^ gmul(a2, 4'd11) ^ gmul(a3, 4'd13);
         o[32*c+16 +: 8] = gmul(a0, 4'd13) ^ gmul(a1, 4'd9) ^ gmul(a2, 4'd14) ^ gmul(a3, 4'd11);
         o[32*c+24 +: 8] = gmul(a0, 4'd11) ^ gmul(a1, 4'd13) ^ gmul(a2, 4'd9) ^ gmul(a3, 4'd14);
      end
      return o;
   endfunction

   function automatic block_type inv_shift_sub(input block_type s);
      block_type t;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[8*(r + 4*c) +: 8] = InvSbox[s[8*(r + 4*((c - r + 4) % 4)) +: 8]];
         end
      end
      return t;
   endfunction

endpackage

FILE: rtl/core/aesd_key_cell.sv
// One key-schedule cell: forward expansion of one round key per cycle.
// Depends on aesd_pkg.
module aesd_key_cell
   import aesd_pkg::*;
(
   input  logic       clock,
   input  logic [7:0] rcon,
   input  block_type  key_prev,
   output block_type  key_next_ff
);

   logic [31:0] w3;
   logic [31:0] t;
   block_type   key_next_in;

   // Rotate, substitute and add round constant on the last word.
   always_comb begin
      w3 = key_prev[127:96];
      t  = {fwd_sub(w3[7:0]), fwd_sub(w3[31:24]), fwd_sub(w3[23:16]),
            fwd_sub(w3[15:8]) ^ rcon};
      key_next_in[31:0]   = key_prev[31:0] ^ t;
      key_next_in[63:32]  = key_prev[63:32] ^ key_next_in[31:0];
      key_next_in[95:64]  = key_prev[95:64] ^ key_next_in[63:32];
      key_next_in[127:96] = key_prev[127:96] ^ key_next_in[95:64];
   end

   always_ff @(posedge clock) begin
      key_next_ff <= key_next_in;
   end

endmodule

FILE: rtl/core/aesd_round_cell.sv
// One decryption round cell of the chain, registered at its output.
// Depends on aesd_pkg.
module aesd_round_cell
   import aesd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  logic      last,
   input  block_type round_key,
   input  stage_type stage_prev,
   output stage_type stage_next_ff
);

   block_type s;
   stage_type stage_next_in;

   // Inverse shift and substitute, mix unless last round, add key.
   always_comb begin
      s = inv_shift_sub(stage_prev.data);
      if (!last) s = inv_mix(s);
      stage_next_in.valid = stage_prev.valid;
      stage_next_in.data  = s ^ round_key;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_next_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_next_ff.valid <= stage_next_in.valid;
      end
      if (advance) stage_next_ff.data <= stage_next_in.data;
   end

endmodule

FILE: rtl/core/aes128_block_decrypt_core.sv
// AES-128 ECB block decryptor: a row of ten round cells plus a key schedule.
// Depends on aesd_pkg, aesd_key_cell, aesd_round_cell and assert_macros.svh.
//
// Channels: req_ (ciphertext halves) and rsp_ (plaintext halves) use valid and
// ready; csr_ writes key_low (index 0) or key_high (index 1), the index being
// a single bit. Write keys only while the block is idle.
// Pipeline: ten register stages, the first loaded at the edge that accepts a
// req_ beat, the last driving rsp_valid. Throughput: one block per cycle;
// the chain of round cells advances whenever the output stage is empty or
// being taken, so back-pressure stalls the whole chain. After a key write the
// schedule row refills through its key cells; req_ready is low during that
// time. Reset clears the key to zero, empties the chain and then expands the
// zero key through the schedule row.
module aes128_block_decrypt_core
   import aesd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_ct_low,
   input  logic [63:0] req_ct_high,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_pt_low,
   output logic [63:0] rsp_pt_high,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [63:0] csr_data
);
`include "assert_macros.svh"

   localparam logic [9:0][7:0] Rcon = {8'h36, 8'h1b, 8'h80, 8'h40, 8'h20,
                                       8'h10, 8'h08, 8'h04, 8'h02, 8'h01};

   logic [63:0]  key_low_ff, key_high_ff;
   logic [3:0]   settle_ff;
   block_type    enc_key [0:NumRounds];
   stage_type    chain [0:NumRounds];
   logic         advance;

   // Key registers; any write restarts the settle count.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
         settle_ff   <= 4'(NumRounds);
      end else if (csr_valid) begin
         if (csr_index == 1'b0) key_low_ff <= csr_data;
         else key_high_ff <= csr_data;
         settle_ff <= 4'(NumRounds);
      end else if (settle_ff != 4'd0) begin
         settle_ff <= settle_ff - 4'd1;
      end
   end

   assign csr_ready = 1'b1;

   // Schedule row: each cell derives the next encryption round key.
   assign enc_key[0] = {key_high_ff, key_low_ff};
   for (genvar i = 0; i < NumRounds; i++) begin : g_key
      aesd_key_cell u_key (
         .clock      (clock),
         .rcon       (Rcon[i]),
         .key_prev   (enc_key[i]),
         .key_next_ff(enc_key[i+1])
      );
   end

   // Round chain: first key addition feeds ten round cells.
   assign advance   = !chain[NumRounds].valid || rsp_ready;
   assign req_ready = advance && (settle_ff == 4'd0);
   assign chain[0].valid = req_valid && req_ready;
   assign chain[0].data  = {req_ct_high, req_ct_low} ^ enc_key[NumRounds];

   for (genvar r = 1; r <= NumRounds; r++) begin : g_round
      aesd_round_cell u_round (
         .clock        (clock),
         .reset        (reset),
         .advance      (advance),
         .last         (r == NumRounds),
         .round_key    ((r == NumRounds) ? enc_key[0] : inv_mix(enc_key[NumRounds-r])),
         .stage_prev   (chain[r-1]),
         .stage_next_ff(chain[r])
      );
   end

   assign rsp_valid   = chain[NumRounds].valid;
   assign rsp_pt_low  = chain[NumRounds].data[63:0];
   assign rsp_pt_high = chain[NumRounds].data[127:64];

   `ASSERT_IMPL(a_no_accept_settling, clock, reset, settle_ff != 4'd0, !req_ready)
   `ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_NEXT(a_write_restarts, clock, reset, csr_valid, settle_ff == 4'(NumRounds))

endmodule

FILE: tb/sv/aes128_block_decrypt_core_tb.sv
// Self-checking testbench for the AES-128 ECB decrypt core.
// Depends on aes128_block_decrypt_core and aesd_pkg; holds its own AES predictor.
`timescale 1ns / 1ps

module aes128_block_decrypt_core_tb;
   import aesd_pkg::*;

   localparam logic CsrKeyLow  = 1'b0;
   localparam logic CsrKeyHigh = 1'b1;
   localparam int   IdlePct    = 23;
   localparam int   StallLimit = 3000;
   localparam int   DrainCycles = 20;
   localparam logic [7:0] RoundConst [0:9] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                               8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

   typedef struct {
      logic [63:0] pt_low;
      logic [63:0] pt_high;
   } plain_beat_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [63:0] req_ct_low;
   logic [63:0] req_ct_high;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [63:0] rsp_pt_low;
   logic [63:0] rsp_pt_high;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [63:0] csr_data;

   // Predictor state: key registers, forward/inverse S-box, encryption round keys.
   logic [63:0]  key_low_reg;
   logic [63:0]  key_high_reg;
   logic [7:0]   sub_fwd [0:255];
   logic [7:0]   sub_inv [0:255];
   logic [127:0] enc_keys [0:10];

   plain_beat_type plain_expected[$];
   int  mismatch_count;
   int  idle_cycles;
   bit  no_idle;

   aes128_block_decrypt_core dut (.*);

   // Clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic [7:0] gf_times(logic [7:0] a, logic [7:0] b);
      logic [7:0] acc;
      acc = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc = acc ^ a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      end
      return acc;
   endfunction

   // Fill both substitution tables from the field inverse and the affine map.
   function automatic void fill_sub_tables();
      logic [7:0] inv;
      logic [7:0] v;
      for (int x = 0; x < 256; x++) begin
         inv = 8'h00;
         for (int y = 1; y < 256; y++) begin
            if (gf_times(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
         end
         v = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
             ^ {inv[3:0], inv[7:4]} ^ 8'h63;
         sub_fwd[x] = v;
         sub_inv[v] = 8'(x);
      end
   endfunction

   // Expand the key registers into the eleven encryption round keys.
   function automatic void expand_round_keys();
      logic [31:0]  w [0:43];
      logic [31:0]  t;
      logic [127:0] kb;
      kb = {key_high_reg, key_low_reg};
      for (int i = 0; i < 4; i++) w[i] = kb[32*i +: 32];
      for (int i = 4; i < 44; i++) begin
         t = w[i-1];
         if (i % 4 == 0) begin
            t = {sub_fwd[t[7:0]], sub_fwd[t[31:24]], sub_fwd[t[23:16]],
                 sub_fwd[t[15:8]] ^ RoundConst[i/4 - 1]};
         end
         w[i] = w[i-4] ^ t;
      end
      for (int r = 0; r <= 10; r++) enc_keys[r] = {w[4*r+3], w[4*r+2], w[4*r+1], w[4*r]};
   endfunction

   function automatic logic [127:0] unshift_unsub(logic [127:0] s);
      logic [127:0] t;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[8*(r + 4*c) +: 8] = sub_inv[s[8*(r + 4*((c - r + 4) % 4)) +: 8]];
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] unmix_columns(logic [127:0] s);
      logic [127:0] t;
      logic [7:0]   a [0:3];
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) a[k] = s[8*(4*c + k) +: 8];
         for (int k = 0; k < 4; k++) begin
            t[8*(4*c + k) +: 8] = gf_times(a[k], 8'h0e) ^ gf_times(a[(k+1)%4], 8'h0b)
                                ^ gf_times(a[(k+2)%4], 8'h0d) ^ gf_times(a[(k+3)%4], 8'h09);
         end
      end
      return t;
   endfunction

   // Straight inverse cipher; matches the equivalent form bit for bit.
   function automatic plain_beat_type decrypt_block(logic [63:0] lo, logic [63:0] hi);
      logic [127:0]   s;
      plain_beat_type p;
      s = {hi, lo} ^ enc_keys[10];
      for (int r = 9; r >= 1; r--) s = unmix_columns(unshift_unsub(s) ^ enc_keys[r]);
      s = unshift_unsub(s) ^ enc_keys[0];
      p.pt_low  = s[63:0];
      p.pt_high = s[127:64];
      return p;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("[%0t] %s mismatch: got %h want %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Track key writes and predict each accepted ciphertext beat.
   always @(posedge clock) begin
      if (!reset && csr_valid && csr_ready) begin
         if (csr_index == CsrKeyLow) key_low_reg = csr_data;
         else key_high_reg = csr_data;
         expand_round_keys();
      end
      if (!reset && req_valid && req_ready)
         plain_expected.push_back(decrypt_block(req_ct_low, req_ct_high));
   end

   // Compare each plaintext beat with the oldest prediction.
   always @(posedge clock) begin
      plain_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (plain_expected.size() == 0) begin
            report_mismatch("unexpected beat pt_low", rsp_pt_low, 'x);
         end else begin
            want = plain_expected.pop_front();
            if (rsp_pt_low !== want.pt_low) report_mismatch("pt_low", rsp_pt_low, want.pt_low);
            if (rsp_pt_high !== want.pt_high)
               report_mismatch("pt_high", rsp_pt_high, want.pt_high);
         end
      end
   end

   // Stall the receiver at random.
   always @(negedge clock) begin
      rsp_ready <= no_idle || ($urandom_range(99) >= IdlePct);
   end

   // Abort when no channel moves for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else if (++idle_cycles >= StallLimit) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Send one ciphertext beat; call and return at a falling edge.
   task automatic send_block(logic [63:0] lo, logic [63:0] hi);
      while (!no_idle && $urandom_range(99) < IdlePct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_ct_low  <= lo;
      req_ct_high <= hi;
      req_valid   <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Hold off until every predicted beat has come back.
   task automatic drain_blocks();
      req_valid <= 1'b0;
      while (plain_expected.size() != 0) @(negedge clock);
   endtask

   task automatic write_key(logic idx, logic [63:0] data);
      drain_blocks();
      csr_index <= idx;
      csr_data  <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Zero key out of reset, field extremes.
   task automatic test_reset_key();
      send_block(64'h0, 64'h0);
      send_block('1, '1);
      send_block(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
      send_block(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
      send_block(64'h0, '1);
   endtask

   // Standard published vector plus a few neighbors.
   task automatic test_standard_vector();
      write_key(CsrKeyLow, 64'h0706_0504_0302_0100);
      write_key(CsrKeyHigh, 64'h0f0e_0d0c_0b0a_0908);
      send_block(64'h3004_7b6a_d8e0_c469, 64'h5ac5_b470_80b7_cdd8);
      send_block(64'h0, 64'h0);
      send_block('1, 64'h0);
   endtask

   // Rewrite one half of the key only; the other half must persist.
   task automatic test_partial_key_update();
      write_key(CsrKeyHigh, '1);
      send_block(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
      write_key(CsrKeyLow, '1);
      send_block(64'h0, 64'h0);
      send_block('1, '1);
      write_key(CsrKeyLow, 64'h0);
      send_block(64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001);
      write_key(CsrKeyHigh, 64'h0);
      send_block('1, '1);
   endtask

   // Random blocks under changing keys, with one long stretch of no idling.
   task automatic test_random_stream();
      for (int i = 0; i < 930; i++) begin
         if (i % 155 == 0) begin
            write_key(CsrKeyLow, rand64());
            write_key(CsrKeyHigh, rand64());
         end
         no_idle = (i >= 300 && i < 450);
         if (i == 600) drain_blocks();
         send_block(rand64(), rand64());
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_ct_low  = '0;
      req_ct_high = '0;
      rsp_ready   = 1'b0;
      csr_valid   = 1'b0;
      csr_index   = CsrKeyLow;
      csr_data    = '0;
      no_idle     = 1'b0;
      mismatch_count = 0;
      idle_cycles = 0;
      key_low_reg  = '0;
      key_high_reg = '0;
      fill_sub_tables();
      expand_round_keys();
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_key();
      test_standard_vector();
      test_partial_key_update();
      test_random_stream();
      drain_blocks();
      repeat (DrainCycles) @(negedge clock);
      if (mismatch_count == 0 && plain_expected.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
